FILE: hw/rtl/aar_pkg.sv
// ----------------------------------------------------------------------------
// aar_pkg
// Shared constants, angle table and flag types for the axis-angle matrix core.
// ----------------------------------------------------------------------------
package aar_pkg;

  localparam int CORDIC_STEPS = 30;
  // fold register, iterations, rounding register
  localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam int QUEUE_DEPTH  = 4;

  typedef struct packed {
    logic zero;
    logic neg_x;
    logic neg_y;
    logic neg_z;
  } axis_flags_t;

  // atan(2^-i), quarter turn = 2^30
  function automatic logic [31:0] atan_at(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2F9;
      15: v = 32'h0000517C;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A2F;
      19: v = 32'h00000517;
      20: v = 32'h0000028B;
      21: v = 32'h00000145;
      22: v = 32'h000000A2;
      23: v = 32'h00000051;
      24: v = 32'h00000028;
      25: v = 32'h00000014;
      26: v = 32'h0000000A;
      27: v = 32'h00000005;
      28: v = 32'h00000002;
      29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/aar_fifo.sv
// ----------------------------------------------------------------------------
// aar_fifo
// Small register queue between the front end and the compute back end.
// ----------------------------------------------------------------------------
module aar_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           data_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           data_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;
  logic             do_pop;

  assign do_pop  = pop_i && (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/aar_delay.sv
// ----------------------------------------------------------------------------
// aar_delay
// Fixed-length valid/data delay line used to align parallel paths.
// ----------------------------------------------------------------------------
module aar_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  if (DEPTH == 0) begin : g_none
    assign valid_o = valid_i;
    assign data_o  = data_i;
  end else begin : g_line
    logic [DEPTH-1:0] vld_q;
    logic [WIDTH-1:0] dat_q [DEPTH];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= '0;
      end else begin
        vld_q <= DEPTH'({vld_q, valid_i});
      end
    end

    always_ff @(posedge clk_i) begin
      dat_q[0] <= data_i;
      for (int i = 1; i < DEPTH; i++) begin
        dat_q[i] <= dat_q[i-1];
      end
    end

    assign valid_o = vld_q[DEPTH-1];
    assign data_o  = dat_q[DEPTH-1];
  end

endmodule

FILE: hw/rtl/aar_front.sv
// ----------------------------------------------------------------------------
// aar_front
// Request intake: magnitudes, sign/zero flags and block-scaling shift.
// ----------------------------------------------------------------------------
module aar_front #(
  parameter int W = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [W-1:0]         axis_x_i,
  input  logic [W-1:0]         axis_y_i,
  input  logic [W-1:0]         axis_z_i,
  input  logic [W-1:0]         angle_i,
  output logic                 valid_o,
  output logic [W-1:0]         mag_x_o,
  output logic [W-1:0]         mag_y_o,
  output logic [W-1:0]         mag_z_o,
  output aar_pkg::axis_flags_t flags_o,
  output logic [W-1:0]         angle_o
);

  localparam int KW = $clog2(W);

  logic [W-1:0] ax, ay, az, mx, my, mz, mmax;
  logic         s1_vld_q;
  logic [W-1:0] s1_mx_q, s1_my_q, s1_mz_q, s1_max_q, s1_ang_q;
  aar_pkg::axis_flags_t s1_flg_q;
  logic [KW-1:0] k;

  assign ax = axis_x_i;
  assign ay = axis_y_i;
  assign az = axis_z_i;
  // two's complement magnitude; most negative input maps to 2^(W-1)
  assign mx = ax[W-1] ? (~ax + 1'b1) : ax;
  assign my = ay[W-1] ? (~ay + 1'b1) : ay;
  assign mz = az[W-1] ? (~az + 1'b1) : az;

  always_comb begin
    mmax = mx;
    if (my > mmax) mmax = my;
    if (mz > mmax) mmax = mz;
  end

  // shift that brings the largest magnitude to bit W-2
  always_comb begin
    k = '0;
    for (int j = 0; j < W-1; j++) begin
      if (s1_max_q[j]) k = KW'(W-2-j);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      valid_o  <= 1'b0;
    end else begin
      s1_vld_q <= valid_i;
      valid_o  <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_mx_q        <= mx;
    s1_my_q        <= my;
    s1_mz_q        <= mz;
    s1_max_q       <= mmax;
    s1_ang_q       <= angle_i;
    s1_flg_q.zero  <= (mmax == '0);
    s1_flg_q.neg_x <= ax[W-1];
    s1_flg_q.neg_y <= ay[W-1];
    s1_flg_q.neg_z <= az[W-1];
    mag_x_o        <= s1_mx_q << k;
    mag_y_o        <= s1_my_q << k;
    mag_z_o        <= s1_mz_q << k;
    flags_o        <= s1_flg_q;
    angle_o        <= s1_ang_q;
  end

endmodule

FILE: hw/rtl/aar_norm.sv
// ----------------------------------------------------------------------------
// aar_norm
// Pipelined axis normalizer: squares, digit-by-digit square root, and three
// restoring dividers, one bit per stage.
// ----------------------------------------------------------------------------
module aar_norm #(
  parameter int W = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [W-1:0]         mag_x_i,
  input  logic [W-1:0]         mag_y_i,
  input  logic [W-1:0]         mag_z_i,
  input  aar_pkg::axis_flags_t flags_i,
  output logic                 valid_o,
  output logic signed [W-1:0]  n_x_o,
  output logic signed [W-1:0]  n_y_o,
  output logic signed [W-1:0]  n_z_o,
  output logic                 zero_o
);

  localparam int F   = W - 2;
  localparam int ND  = 2*W - 1;
  localparam int SQS = W + 1;
  localparam int DVS = F + 1;
  localparam int NST = 2 + SQS + DVS + 1;

  logic [NST-1:0]       vld_q;
  aar_pkg::axis_flags_t flg_q [NST];
  logic [W-1:0]         mag_in [3];
  logic [2*W-1:0]       sq_q [3];
  logic [W-1:0]         mag_a_q [3];
  logic [W-1:0]         mag_b_q [3];
  logic [2*W-1:0]       sum_q;

  // square-root stages
  logic [W:0]           rt_q [SQS];
  logic [W+3:0]         rm_q [SQS];
  logic [2*W-1:0]       sv_q [SQS];
  logic [W-1:0]         mg_q [SQS][3];

  // divider stages
  logic [ND-1:0]        dn_q [DVS][3];
  logic [W:0]           dr_q [DVS];
  logic [W:0]           drem_q [DVS][3];
  logic [F:0]           dq_q [DVS][3];

  logic signed [W-1:0]  n_q [3];

  assign mag_in[0] = mag_x_i;
  assign mag_in[1] = mag_y_i;
  assign mag_in[2] = mag_z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NST-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    flg_q[0] <= flags_i;
    for (int i = 1; i < NST; i++) begin
      flg_q[i] <= flg_q[i-1];
    end
    for (int c = 0; c < 3; c++) begin
      sq_q[c]    <= (2*W)'(mag_in[c]) * (2*W)'(mag_in[c]);
      mag_a_q[c] <= mag_in[c];
      mag_b_q[c] <= mag_a_q[c];
    end
    sum_q <= sq_q[0] + sq_q[1] + sq_q[2];
  end

  for (genvar j = 0; j < SQS; j++) begin : g_sqrt
    logic [W:0]       rt_p;
    logic [W+3:0]     rm_p, rm_sh, trial;
    logic [2*W-1:0]   v_p;
    logic [2*W+1:0]   vpad;
    logic [W-1:0]     mg_p [3];
    logic             ge;

    if (j == 0) begin : g_first
      assign rt_p = '0;
      assign rm_p = '0;
      assign v_p  = sum_q;
      assign mg_p = mag_b_q;
    end else begin : g_next
      assign rt_p = rt_q[j-1];
      assign rm_p = rm_q[j-1];
      assign v_p  = sv_q[j-1];
      assign mg_p = mg_q[j-1];
    end

    assign vpad  = {2'b00, v_p};
    assign rm_sh = {rm_p[W+1:0], vpad[2*(W-j)+1 -: 2]};
    assign trial = {1'b0, rt_p, 2'b01};
    assign ge    = (rm_sh >= trial);

    always_ff @(posedge clk_i) begin
      rt_q[j] <= {rt_p[W-1:0], ge};
      rm_q[j] <= ge ? (rm_sh - trial) : rm_sh;
      sv_q[j] <= v_p;
      mg_q[j] <= mg_p;
    end
  end

  for (genvar d = 0; d < DVS; d++) begin : g_div
    logic [W:0]    r_p;
    logic [ND-1:0] n_p [3];
    logic [W:0]    rem_p [3];
    logic [F:0]    q_p [3];

    if (d == 0) begin : g_first
      assign r_p = rt_q[SQS-1];
      for (genvar c = 0; c < 3; c++) begin : g_c
        // (mag << F) + r/2, quotient known to fit F+1 bits
        assign n_p[c]   = (ND'(mg_q[SQS-1][c]) << F) + ND'(r_p >> 1);
        assign rem_p[c] = (W+1)'(n_p[c][ND-1:F+1]);
        assign q_p[c]   = '0;
      end
    end else begin : g_next
      assign r_p   = dr_q[d-1];
      assign n_p   = dn_q[d-1];
      assign rem_p = drem_q[d-1];
      assign q_p   = dq_q[d-1];
    end

    for (genvar c = 0; c < 3; c++) begin : g_lane
      logic [W+1:0] rs;
      logic         ge;
      assign rs = {rem_p[c], n_p[c][F-d]};
      assign ge = (rs >= {1'b0, r_p});
      always_ff @(posedge clk_i) begin
        drem_q[d][c] <= ge ? (rs[W:0] - r_p) : rs[W:0];
        dq_q[d][c]   <= {q_p[c][F-1:0], ge};
        dn_q[d][c]   <= n_p[c];
      end
    end

    always_ff @(posedge clk_i) begin
      dr_q[d] <= r_p;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q[0] <= flg_q[NST-2].zero ? '0 :
              flg_q[NST-2].neg_x ? -$signed(W'(dq_q[DVS-1][0])) : $signed(W'(dq_q[DVS-1][0]));
    n_q[1] <= flg_q[NST-2].zero ? '0 :
              flg_q[NST-2].neg_y ? -$signed(W'(dq_q[DVS-1][1])) : $signed(W'(dq_q[DVS-1][1]));
    n_q[2] <= flg_q[NST-2].zero ? '0 :
              flg_q[NST-2].neg_z ? -$signed(W'(dq_q[DVS-1][2])) : $signed(W'(dq_q[DVS-1][2]));
  end

  assign valid_o = vld_q[NST-1];
  assign n_x_o   = n_q[0];
  assign n_y_o   = n_q[1];
  assign n_z_o   = n_q[2];
  assign zero_o  = flg_q[NST-1].zero;

endmodule

FILE: hw/rtl/aar_cordic.sv
// ----------------------------------------------------------------------------
// aar_cordic
// Pipelined rotation-mode CORDIC, one iteration per stage, with half-turn fold.
// ----------------------------------------------------------------------------
module aar_cordic #(
  parameter int W = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [W-1:0]        angle_i,
  output logic                valid_o,
  output logic signed [W:0]   sin_o,
  output logic signed [W:0]   cos_o
);

  localparam int N  = aar_pkg::CORDIC_STEPS;
  localparam int SH = 32 - W;

  logic [N+1:0]        vld_q;
  logic signed [33:0]  cx_q [N+1];
  logic signed [33:0]  cy_q [N+1];
  logic signed [33:0]  cz_q [N+1];
  logic                flp_q [N+1];
  logic [31:0]         th0, thf;
  logic                flip;
  logic signed [W:0]   xr, yr;

  assign th0  = 32'(angle_i) << SH;
  assign flip = th0[31] ^ th0[30];
  assign thf  = flip ? (th0 ^ 32'h8000_0000) : th0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[N:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q[0]  <= aar_pkg::CORDIC_GAIN;
    cy_q[0]  <= '0;
    cz_q[0]  <= $signed({{2{thf[31]}}, thf});
    flp_q[0] <= flip;
  end

  for (genvar i = 1; i <= N; i++) begin : g_iter
    logic signed [33:0] dx, dy, at;
    assign dx = cy_q[i-1] >>> (i-1);
    assign dy = cx_q[i-1] >>> (i-1);
    assign at = $signed({2'b00, aar_pkg::atan_at(i-1)});
    always_ff @(posedge clk_i) begin
      if (!cz_q[i-1][33]) begin
        cx_q[i] <= cx_q[i-1] - dx;
        cy_q[i] <= cy_q[i-1] + dy;
        cz_q[i] <= cz_q[i-1] - at;
      end else begin
        cx_q[i] <= cx_q[i-1] + dx;
        cy_q[i] <= cy_q[i-1] - dy;
        cz_q[i] <= cz_q[i-1] + at;
      end
      flp_q[i] <= flp_q[i-1];
    end
  end

  if (SH > 0) begin : g_rnd
    logic signed [33:0] xs, ys;
    assign xs = (cx_q[N] + (34'sd1 <<< (SH-1))) >>> SH;
    assign ys = (cy_q[N] + (34'sd1 <<< (SH-1))) >>> SH;
    assign xr = xs[W:0];
    assign yr = ys[W:0];
  end else begin : g_full
    assign xr = cx_q[N][W:0];
    assign yr = cy_q[N][W:0];
  end

  always_ff @(posedge clk_i) begin
    cos_o <= flp_q[N] ? -xr : xr;
    sin_o <= flp_q[N] ? -yr : yr;
  end

  assign valid_o = vld_q[N+1];

endmodule

FILE: hw/rtl/aar_matrix.sv
// ----------------------------------------------------------------------------
// aar_matrix
// Three-stage matrix assembly: pair products, t scaling, sums with saturation.
// ----------------------------------------------------------------------------
module aar_matrix #(
  parameter int W = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic signed [W-1:0] n_x_i,
  input  logic signed [W-1:0] n_y_i,
  input  logic signed [W-1:0] n_z_i,
  input  logic signed [W:0]   sin_i,
  input  logic signed [W:0]   cos_i,
  input  logic                zero_i,
  output logic                valid_o,
  output logic [8:0][W-1:0]   m_o,
  output logic                zero_o
);

  localparam int F  = W - 2;
  localparam int PW = 2*W + 2;
  localparam logic signed [PW-1:0] HALF = PW'(1) << (F-1);
  localparam logic signed [W:0]    ONE  = (W+1)'(1) << F;
  localparam logic signed [W+1:0]  HI   = (W+2)'((1 << (W-1)) - 1);
  localparam logic signed [W+1:0]  LO   = -((W+2)'(1) << (W-1));

  // pair indexes
  localparam int XX = 0, YY = 1, ZZ = 2, XY = 3, XZ = 4, YZ = 5;

  logic [2:0]          vld_q;
  logic [1:0]          zr_q;
  logic signed [W:0]   p_q [6];
  logic signed [W:0]   s_q [3];
  logic signed [W:0]   t_q, c_q, c2_q;
  logic signed [W:0]   tp_q [6];
  logic signed [W:0]   s2_q [3];
  logic signed [W-1:0] nn [3];
  logic signed [W+1:0] e [9];

  function automatic logic signed [W:0] rnd(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] r;
    r = (v + HALF) >>> F;
    return r[W:0];
  endfunction

  function automatic logic [W-1:0] sat(input logic signed [W+1:0] v);
    logic signed [W+1:0] r;
    r = v;
    if (v > HI) r = HI;
    if (v < LO) r = LO;
    return r[W-1:0];
  endfunction

  function automatic logic signed [PW-1:0] mul(input logic signed [W:0] a,
                                               input logic signed [W:0] b);
    return PW'(a) * PW'(b);
  endfunction

  assign nn[0] = n_x_i;
  assign nn[1] = n_y_i;
  assign nn[2] = n_z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    p_q[XX] <= rnd(mul(nn[0], nn[0]));
    p_q[YY] <= rnd(mul(nn[1], nn[1]));
    p_q[ZZ] <= rnd(mul(nn[2], nn[2]));
    p_q[XY] <= rnd(mul(nn[0], nn[1]));
    p_q[XZ] <= rnd(mul(nn[0], nn[2]));
    p_q[YZ] <= rnd(mul(nn[1], nn[2]));
    for (int c = 0; c < 3; c++) begin
      s_q[c] <= rnd(mul(sin_i, nn[c]));
    end
    t_q   <= ONE - cos_i;
    c_q   <= cos_i;
    zr_q  <= {zr_q[0], zero_i};
    for (int k = 0; k < 6; k++) begin
      tp_q[k] <= rnd(mul(t_q, p_q[k]));
    end
    s2_q  <= s_q;
    c2_q  <= c_q;
    m_o[0] <= sat(e[0]);
    m_o[1] <= sat(e[1]);
    m_o[2] <= sat(e[2]);
    m_o[3] <= sat(e[3]);
    m_o[4] <= sat(e[4]);
    m_o[5] <= sat(e[5]);
    m_o[6] <= sat(e[6]);
    m_o[7] <= sat(e[7]);
    m_o[8] <= sat(e[8]);
    zero_o <= zr_q[1];
  end

  always_comb begin
    e[0] = (W+2)'(tp_q[XX]) + (W+2)'(c2_q);
    e[1] = (W+2)'(tp_q[XY]) - (W+2)'(s2_q[2]);
    e[2] = (W+2)'(tp_q[XZ]) + (W+2)'(s2_q[1]);
    e[3] = (W+2)'(tp_q[XY]) + (W+2)'(s2_q[2]);
    e[4] = (W+2)'(tp_q[YY]) + (W+2)'(c2_q);
    e[5] = (W+2)'(tp_q[YZ]) - (W+2)'(s2_q[0]);
    e[6] = (W+2)'(tp_q[XZ]) - (W+2)'(s2_q[1]);
    e[7] = (W+2)'(tp_q[YZ]) + (W+2)'(s2_q[0]);
    e[8] = (W+2)'(tp_q[ZZ]) + (W+2)'(c2_q);
  end

  assign valid_o = vld_q[2];

endmodule

FILE: hw/rtl/axis_angle_rotation_matrix_core.sv
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix_core
// Axis-angle to 3x3 rotation matrix, fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   A request (axis x/y/z, Q1.(W-2), any length, plus a binary angle) is
//   taken at a rising edge with start high and busy low. One request per
//   cycle is accepted back to back.
//   The matrix appears on m00_o..m22_o with zero_axis_o for exactly one
//   cycle, marked by done_o. There is no back pressure on results.
//   From accept to done a request passes two front stages, one queue
//   stage, the longer back path and three matrix stages. The back path is
//   the longer of the normalizer pipeline (two squaring stages, one stage
//   per square-root bit, one per quotient bit and a sign stage) and the
//   32-stage CORDIC, which runs beside it; the shorter path is delayed to
//   match.
//   Throughput: one request per cycle. busy only rises if the front/back
//   queue holds QD-2 entries, which cannot happen as the back end never stalls.
//   Reset (rst_ni low, async) empties the queue and drops all requests in
//   flight; no result is produced for them.
//   A zero axis yields cos on the diagonal, zeros elsewhere, zero_axis_o=1.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix_core #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [DATA_WIDTH-1:0] axis_x_i,
  input  logic [DATA_WIDTH-1:0] axis_y_i,
  input  logic [DATA_WIDTH-1:0] axis_z_i,
  input  logic [DATA_WIDTH-1:0] rot_angle_i,
  output logic                  done_o,
  output logic [DATA_WIDTH-1:0] m00_o,
  output logic [DATA_WIDTH-1:0] m01_o,
  output logic [DATA_WIDTH-1:0] m02_o,
  output logic [DATA_WIDTH-1:0] m10_o,
  output logic [DATA_WIDTH-1:0] m11_o,
  output logic [DATA_WIDTH-1:0] m12_o,
  output logic [DATA_WIDTH-1:0] m20_o,
  output logic [DATA_WIDTH-1:0] m21_o,
  output logic [DATA_WIDTH-1:0] m22_o,
  output logic                  zero_axis_o
);

  localparam int W     = DATA_WIDTH;
  localparam int QD    = aar_pkg::QUEUE_DEPTH;
  localparam int QW    = 4*W + 4;
  localparam int CW    = $clog2(QD+1);
  localparam int LN    = 2*W + 3;               // normalizer latency
  localparam int LC    = aar_pkg::CORDIC_LAT;   // sine/cosine latency
  localparam int LM    = (LN > LC) ? LN : LC;
  localparam int NW    = 3*W + 1;
  localparam int SW    = 2*W + 2;

  // front end
  logic                 fr_vld;
  logic [W-1:0]         fr_mx, fr_my, fr_mz, fr_ang;
  aar_pkg::axis_flags_t fr_flg;

  // queue
  logic [QW-1:0]        q_din, q_dout;
  logic                 q_empty;
  logic [CW-1:0]        q_cnt;
  logic                 bk_vld;
  logic [W-1:0]         bk_mx, bk_my, bk_mz, bk_ang;
  aar_pkg::axis_flags_t bk_flg;

  // back end
  logic                 nr_vld, nr_zero;
  logic signed [W-1:0]  nr_x, nr_y, nr_z;
  logic                 cr_vld;
  logic signed [W:0]    cr_sin, cr_cos;
  logic                 na_vld, ca_vld;
  logic [NW-1:0]        na_dat;
  logic [SW-1:0]        ca_dat;
  logic [8:0][W-1:0]    mat;

  // Two front stages may still push after busy rises, so leave headroom.
  assign busy = (q_cnt >= CW'(QD-2));

  aar_front #(.W(W)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (start && !busy),
    .axis_x_i (axis_x_i),
    .axis_y_i (axis_y_i),
    .axis_z_i (axis_z_i),
    .angle_i  (rot_angle_i),
    .valid_o  (fr_vld),
    .mag_x_o  (fr_mx),
    .mag_y_o  (fr_my),
    .mag_z_o  (fr_mz),
    .flags_o  (fr_flg),
    .angle_o  (fr_ang)
  );

  assign q_din = {fr_mx, fr_my, fr_mz, fr_flg, fr_ang};

  aar_fifo #(.WIDTH(QW), .DEPTH(QD)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_vld),
    .data_i  (q_din),
    .pop_i   (1'b1),
    .data_o  (q_dout),
    .empty_o (q_empty),
    .count_o (q_cnt)
  );

  // back end never stalls: pop whenever something is queued
  assign bk_vld = !q_empty;
  assign {bk_mx, bk_my, bk_mz, bk_flg, bk_ang} = q_dout;

  aar_norm #(.W(W)) u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (bk_vld),
    .mag_x_i (bk_mx),
    .mag_y_i (bk_my),
    .mag_z_i (bk_mz),
    .flags_i (bk_flg),
    .valid_o (nr_vld),
    .n_x_o   (nr_x),
    .n_y_o   (nr_y),
    .n_z_o   (nr_z),
    .zero_o  (nr_zero)
  );

  aar_cordic #(.W(W)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (bk_vld),
    .angle_i (bk_ang),
    .valid_o (cr_vld),
    .sin_o   (cr_sin),
    .cos_o   (cr_cos)
  );

  // pad the shorter of the two paths
  aar_delay #(.WIDTH(NW), .DEPTH(LM-LN)) u_norm_dly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (nr_vld),
    .data_i  ({nr_x, nr_y, nr_z, nr_zero}),
    .valid_o (na_vld),
    .data_o  (na_dat)
  );

  aar_delay #(.WIDTH(SW), .DEPTH(LM-LC)) u_cordic_dly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cr_vld),
    .data_i  ({cr_sin, cr_cos}),
    .valid_o (ca_vld),
    .data_o  (ca_dat)
  );

  aar_matrix #(.W(W)) u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (na_vld),
    .n_x_i   ($signed(na_dat[NW-1 -: W])),
    .n_y_i   ($signed(na_dat[2*W : W+1])),
    .n_z_i   ($signed(na_dat[W:1])),
    .sin_i   ($signed(ca_dat[SW-1 -: W+1])),
    .cos_i   ($signed(ca_dat[W:0])),
    .zero_i  (na_dat[0]),
    .valid_o (done_o),
    .m_o     (mat),
    .zero_o  (zero_axis_o)
  );

  assign m00_o = mat[0];
  assign m01_o = mat[1];
  assign m02_o = mat[2];
  assign m10_o = mat[3];
  assign m11_o = mat[4];
  assign m12_o = mat[5];
  assign m20_o = mat[6];
  assign m21_o = mat[7];
  assign m22_o = mat[8];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // axis and angle paths must meet at the matrix stage in the same cycle
  a_paths_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    na_vld == ca_vld)
    else $error("normalizer and cordic paths out of step");

  // headroom on busy keeps the queue from overflowing
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt <= CW'(QD))
    else $error("request queue overflow");

  // zero axis: off-diagonal entries zero, diagonal entries all equal
  a_zero_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && zero_axis_o |-> (m01_o == '0) && (m02_o == '0) && (m10_o == '0) &&
      (m12_o == '0) && (m20_o == '0) && (m21_o == '0) &&
      (m00_o == m11_o) && (m11_o == m22_o))
    else $error("zero-axis result malformed");

endmodule
